### src/flow_hash_wan_balancer_core_macros.svh
// Assertion macros used by the checker of the flow balancer.
// No dependencies; every macro samples on i_clk and is held off while i_rst_n is low.
`ifndef FLOW_HASH_WAN_BALANCER_CORE_MACROS_SVH
`define FLOW_HASH_WAN_BALANCER_CORE_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent must hold too.
`define FHWB_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("fhwb assertion failed");

// Next-cycle implication: when the antecedent holds, the consequent must hold in the following cycle.
`define FHWB_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("fhwb assertion failed");

`endif

### src/fhwb_pkg.sv
// Shared types and constants for the flow hash WAN balancer.
// Used by the register file, the controller, the datapath and the top level.
package fhwb_pkg;

    // Field widths fixed by the packet and MAC formats.
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 16;
    localparam int COUNT_W = 21;
    localparam int LINK_W  = 2;
    localparam int MAC_W   = 48;
    localparam int NUM_W   = 2;

    // Highest number of links that the rotation may use.
    localparam int MAX_LINKS = 3;

    // Configuration port geometry: eight 64-bit registers at 8-byte spacing.
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int REG_W   = 3;

    localparam logic [REG_W-1:0] REG_NUM_WANS     = 3'd0;
    localparam logic [REG_W-1:0] REG_WINDOW_BYTES = 3'd1;
    localparam logic [REG_W-1:0] REG_WAN0_DST_MAC = 3'd2;
    localparam logic [REG_W-1:0] REG_WAN1_DST_MAC = 3'd3;
    localparam logic [REG_W-1:0] REG_WAN2_DST_MAC = 3'd4;
    localparam logic [REG_W-1:0] REG_WAN0_SRC_MAC = 3'd5;
    localparam logic [REG_W-1:0] REG_WAN1_SRC_MAC = 3'd6;
    localparam logic [REG_W-1:0] REG_WAN2_SRC_MAC = 3'd7;

    // Link codes that select a MAC pair.
    localparam logic [LINK_W-1:0] LINK_0 = 2'd0;
    localparam logic [LINK_W-1:0] LINK_1 = 2'd1;
    localparam logic [LINK_W-1:0] LINK_2 = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [NUM_W-1:0]   NUM_WANS_RST = 2'd1;
    localparam logic [COUNT_W-1:0] WINDOW_RST   = 21'h10000;

    // One flow table entry.
    typedef struct packed {
        logic [LINK_W-1:0]  link;
        logic [COUNT_W-1:0] count;
    } t_flow_entry;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [NUM_W-1:0]        num_wans;
        logic [COUNT_W-1:0]      window_bytes;
        logic [2:0][MAC_W-1:0]   dst_mac;
        logic [2:0][MAC_W-1:0]   src_mac;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic lookup;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_sts;

    // Active link count: zero acts as one, and the count is capped at MAX_LINKS.
    function automatic logic [NUM_W-1:0] active_links(input logic [NUM_W-1:0] n);
        logic [NUM_W-1:0] a;
        a = (n == '0) ? NUM_W'(1) : n;
        if (32'(a) > MAX_LINKS) a = NUM_W'(MAX_LINKS);
        return a;
    endfunction

endpackage

### src/fhwb_regs.sv
// Configuration register file of the flow balancer behind an APB-style port.
// Depends on fhwb_pkg for register indexes, widths and reset values.
module fhwb_regs
    import fhwb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [NUM_W-1:0]      r_num_wans;
    logic [COUNT_W-1:0]    r_window_bytes;
    logic [2:0][MAC_W-1:0] r_dst_mac;
    logic [2:0][MAC_W-1:0] r_src_mac;
    logic [REG_W-1:0]      reg_idx;
    logic                  wr_en;

    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes complete in the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_wans     <= NUM_WANS_RST;
            r_window_bytes <= WINDOW_RST;
            r_dst_mac      <= '0;
            r_src_mac      <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NUM_WANS:     r_num_wans     <= pwdata[NUM_W-1:0];
                REG_WINDOW_BYTES: r_window_bytes <= pwdata[COUNT_W-1:0];
                REG_WAN0_DST_MAC: r_dst_mac[0]   <= pwdata[MAC_W-1:0];
                REG_WAN1_DST_MAC: r_dst_mac[1]   <= pwdata[MAC_W-1:0];
                REG_WAN2_DST_MAC: r_dst_mac[2]   <= pwdata[MAC_W-1:0];
                REG_WAN0_SRC_MAC: r_src_mac[0]   <= pwdata[MAC_W-1:0];
                REG_WAN1_SRC_MAC: r_src_mac[1]   <= pwdata[MAC_W-1:0];
                REG_WAN2_SRC_MAC: r_src_mac[2]   <= pwdata[MAC_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data is the addressed register, zero extended.
    always_comb begin
        unique case (reg_idx)
            REG_NUM_WANS:     prdata = PDATA_W'(r_num_wans);
            REG_WINDOW_BYTES: prdata = PDATA_W'(r_window_bytes);
            REG_WAN0_DST_MAC: prdata = PDATA_W'(r_dst_mac[0]);
            REG_WAN1_DST_MAC: prdata = PDATA_W'(r_dst_mac[1]);
            REG_WAN2_DST_MAC: prdata = PDATA_W'(r_dst_mac[2]);
            REG_WAN0_SRC_MAC: prdata = PDATA_W'(r_src_mac[0]);
            REG_WAN1_SRC_MAC: prdata = PDATA_W'(r_src_mac[1]);
            REG_WAN2_SRC_MAC: prdata = PDATA_W'(r_src_mac[2]);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.num_wans     = r_num_wans;
    assign o_cfg.window_bytes = r_window_bytes;
    assign o_cfg.dst_mac      = r_dst_mac;
    assign o_cfg.src_mac      = r_src_mac;

endmodule

### src/fhwb_ctrl.sv
// Controller of the flow balancer: table clearing, lookup and commit sequencing.
// Depends on fhwb_pkg for the command and status structs.
module fhwb_ctrl
    import fhwb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;

    // Next state: clear the table once, then alternate lookup and update.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_sts.clear_last) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_UPDATE;
            S_UPDATE: if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // State and the registered input stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    // Commands to the datapath.
    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.lookup = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit = (r_state == S_UPDATE) && i_sts.out_free;
    assign o_in_stall   = r_in_stall;

endmodule

### src/fhwb_dpath.sv
// Datapath of the flow balancer: flow table memory, window update and result register.
// Depends on fhwb_pkg for widths, structs and the active link function.
module fhwb_dpath
    import fhwb_pkg::*;
#(
    parameter int FLOW_ENTRIES = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  t_cfg               i_cfg,
    input  logic [ADDR_W-1:0]  i_source_address,
    input  logic [ADDR_W-1:0]  i_destination_address,
    input  logic [LEN_W-1:0]   i_total_length,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [LINK_W-1:0]  o_link_index,
    output logic [MAC_W-1:0]   o_rewrite_dst_mac,
    output logic [MAC_W-1:0]   o_rewrite_src_mac
);

    localparam int IDX_W = $clog2(FLOW_ENTRIES);

    t_flow_entry r_table [FLOW_ENTRIES];
    t_flow_entry r_rd_data;
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] r_slot;
    logic [LEN_W-1:0] r_len;
    logic             r_out_valid;
    logic [LINK_W-1:0] r_link;
    logic [MAC_W-1:0]  r_dst_mac;
    logic [MAC_W-1:0]  r_src_mac;

    logic [ADDR_W-1:0]  addr_xor;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    t_flow_entry        n_entry;
    logic [COUNT_W:0]   sum;
    logic               rotate;
    logic [LINK_W:0]    link_inc;
    logic [NUM_W-1:0]   act;
    logic [LINK_W-1:0]  n_link;
    logic [MAC_W-1:0]   n_dst_mac;
    logic [MAC_W-1:0]   n_src_mac;

    // Flow slot is the low bits of the address XOR.
    assign addr_xor = i_source_address ^ i_destination_address;
    assign rd_addr  = addr_xor[IDX_W-1:0];

    // Window update on the entry read for the current packet.
    assign sum      = {1'b0, r_rd_data.count} + (COUNT_W + 1)'(r_len);
    assign rotate   = (sum >= {1'b0, i_cfg.window_bytes});
    assign act      = active_links(i_cfg.num_wans);
    assign link_inc = {1'b0, r_rd_data.link} + (LINK_W + 1)'(1);

    always_comb begin
        n_link = r_rd_data.link;
        n_entry.link  = r_rd_data.link;
        n_entry.count = sum[COUNT_W-1:0];
        if (rotate) begin
            n_link = (link_inc >= (LINK_W + 1)'(act)) ? LINK_0 : link_inc[LINK_W-1:0];
            n_entry.link  = n_link;
            n_entry.count = '0;
        end
    end

    // MAC pair of the chosen link; links without a register use link 0.
    always_comb begin
        case (n_link)
            LINK_1: begin
                n_dst_mac = i_cfg.dst_mac[1];
                n_src_mac = i_cfg.src_mac[1];
            end
            LINK_2: begin
                n_dst_mac = i_cfg.dst_mac[2];
                n_src_mac = i_cfg.src_mac[2];
            end
            default: begin
                n_dst_mac = i_cfg.dst_mac[0];
                n_src_mac = i_cfg.src_mac[0];
            end
        endcase
    end

    // Table write port: zeros during the clearing pass, updated entry on commit.
    assign wr_en   = i_cmd.clear || i_cmd.commit;
    assign wr_addr = i_cmd.clear ? r_clr_idx : r_slot;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= i_cmd.clear ? t_flow_entry'('0) : n_entry;
        end
        if (i_cmd.lookup) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    // Clearing pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + IDX_W'(1);
        end
    end

    // Packet context held while the table entry is read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_slot <= rd_addr;
            r_len  <= i_total_length;
        end
    end

    // Result register: loaded on commit, emptied when the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_link    <= n_link;
            r_dst_mac <= n_dst_mac;
            r_src_mac <= n_src_mac;
        end
    end

    assign o_sts.clear_last = (r_clr_idx == IDX_W'(FLOW_ENTRIES - 1));
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_link_index      = r_link;
    assign o_rewrite_dst_mac = r_dst_mac;
    assign o_rewrite_src_mac = r_src_mac;

endmodule

### src/flow_hash_wan_balancer_core.sv
// Top level of the flow hash WAN balancer: register file, controller and datapath.
// Depends on fhwb_pkg, fhwb_regs, fhwb_ctrl and fhwb_dpath.
//
//   Channel  Direction  Handshake               Contents
//   in       input      i_in_valid / o_in_stall source, destination address, total length
//   out      output     o_out_valid / i_out_stall link index, rewrite dst and src MAC
//   cfg      input      psel, penable, pwrite   eight 64-bit registers at 8-byte spacing
//
// Each packet is handled in two steps: a lookup reads its flow table entry from the single-port
// table memory, then an update writes the entry back and loads the result register.
// After reset a clearing pass zeroes all FLOW_ENTRIES table entries; o_in_stall is
// high throughout the pass, while configuration writes are taken as usual.
// A result waiting under i_out_stall does not block the next accept; its update waits.
module flow_hash_wan_balancer_core
    import fhwb_pkg::*;
#(
    parameter int FLOW_ENTRIES = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ADDR_W-1:0]  i_source_address,
    input  logic [ADDR_W-1:0]  i_destination_address,
    input  logic [LEN_W-1:0]   i_total_length,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [LINK_W-1:0]  o_link_index,
    output logic [MAC_W-1:0]   o_rewrite_dst_mac,
    output logic [MAC_W-1:0]   o_rewrite_src_mac
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // Configuration registers.
    fhwb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencing of clearing, lookup and commit.
    fhwb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Flow table and result path.
    fhwb_dpath #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .i_cfg                 (cfg),
        .i_source_address      (i_source_address),
        .i_destination_address (i_destination_address),
        .i_total_length        (i_total_length),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_link_index          (o_link_index),
        .o_rewrite_dst_mac     (o_rewrite_dst_mac),
        .o_rewrite_src_mac     (o_rewrite_src_mac)
    );

endmodule

### src/fhwb_checker.sv
// Port-level checker for the flow balancer, bound to the top level.
// Depends on fhwb_pkg and the assertion macros header.
`include "flow_hash_wan_balancer_core_macros.svh"

module fhwb_checker
    import fhwb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [LINK_W-1:0] o_link_index,
    input logic [MAC_W-1:0]  o_rewrite_dst_mac,
    input logic [MAC_W-1:0]  o_rewrite_src_mac
);

    // A stalled result keeps its payload.
    `FHWB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_link_index) && $stable(o_rewrite_dst_mac) && $stable(o_rewrite_src_mac))

    // Only links 0 to 2 are ever chosen.
    `FHWB_ASSERT_NOW(a_link_range, o_out_valid, o_link_index != 2'd3)

    // One packet at a time: the table update follows every accepted transaction.
    `FHWB_ASSERT_NEXT(a_one_at_a_time, i_in_valid && !o_in_stall, o_in_stall)

    // A new result only appears after a packet was taken in and is being updated.
    `FHWB_ASSERT_NOW(a_result_after_update, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind flow_hash_wan_balancer_core fhwb_checker u_fhwb_checker (.*);

### verif/tb.sv
// Self-checking testbench for flow_hash_wan_balancer_core: drives packets and register writes,
// predicts the chosen WAN link and rewrite MACs per packet, and checks every result in order.
// Depends on fhwb_pkg and the RTL of flow_hash_wan_balancer_core only.
`timescale 1ns / 1ps

module tb
    import fhwb_pkg::*;
();

    localparam int FLOW_SLOTS   = 8192;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int POOL_FLOWS   = 12;

    // Expected content of one output transaction.
    typedef struct packed {
        logic [LINK_W-1:0] link;
        logic [MAC_W-1:0]  dst_mac;
        logic [MAC_W-1:0]  src_mac;
    } t_rewrite;

    // Mirrors the flow table and registers, and keeps the rewrites still owed by the block.
    class rewrite_board #(int SLOTS = 8192);
        logic [NUM_W-1:0]   num_wans;
        logic [COUNT_W-1:0] window;
        logic [MAC_W-1:0]   dst_mac [3];
        logic [MAC_W-1:0]   src_mac [3];
        logic [COUNT_W-1:0] slot_bytes [SLOTS];
        logic [LINK_W-1:0]  slot_link [SLOTS];
        t_rewrite           pending [$];
        int                 errors;

        function new();
            num_wans = NUM_WANS_RST;
            window   = WINDOW_RST;
            errors   = 0;
            foreach (dst_mac[i]) begin
                dst_mac[i] = '0;
                src_mac[i] = '0;
            end
            foreach (slot_bytes[i]) begin
                slot_bytes[i] = '0;
                slot_link[i]  = LINK_0;
            end
        endfunction

        function void write_reg(logic [REG_W-1:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_NUM_WANS:     num_wans   = val[NUM_W-1:0];
                REG_WINDOW_BYTES: window     = val[COUNT_W-1:0];
                REG_WAN0_DST_MAC: dst_mac[0] = val[MAC_W-1:0];
                REG_WAN1_DST_MAC: dst_mac[1] = val[MAC_W-1:0];
                REG_WAN2_DST_MAC: dst_mac[2] = val[MAC_W-1:0];
                REG_WAN0_SRC_MAC: src_mac[0] = val[MAC_W-1:0];
                REG_WAN1_SRC_MAC: src_mac[1] = val[MAC_W-1:0];
                REG_WAN2_SRC_MAC: src_mac[2] = val[MAC_W-1:0];
                default: ;
            endcase
        endfunction

        // Update the flow's byte window and link, then queue the rewrite it calls for.
        function void note_packet(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] d,
                                  logic [LEN_W-1:0] l);
            int unsigned      slot;
            logic [COUNT_W:0] total;
            int               lanes;
            int               nxt;
            t_rewrite         r;
            slot   = (s ^ d) & (SLOTS - 1);
            total  = {1'b0, slot_bytes[slot]} + (COUNT_W + 1)'(l);
            r.link = slot_link[slot];
            // A zero link count acts as one, and the count never exceeds MAX_LINKS.
            lanes = (num_wans == '0) ? 1 : int'(num_wans);
            if (lanes > MAX_LINKS) lanes = MAX_LINKS;
            if (total >= {1'b0, window}) begin
                nxt    = int'(r.link) + 1;
                r.link = (nxt >= lanes) ? LINK_0 : LINK_W'(nxt);
                slot_link[slot]  = r.link;
                slot_bytes[slot] = '0;
            end else begin
                slot_bytes[slot] = total[COUNT_W-1:0];
            end
            case (r.link)
                LINK_1: begin
                    r.dst_mac = dst_mac[1];
                    r.src_mac = src_mac[1];
                end
                LINK_2: begin
                    r.dst_mac = dst_mac[2];
                    r.src_mac = src_mac[2];
                end
                default: begin
                    r.dst_mac = dst_mac[0];
                    r.src_mac = src_mac[0];
                end
            endcase
            pending.push_back(r);
        endfunction

        function void flag(string what, logic [MAC_W-1:0] exp_v, logic [MAC_W-1:0] act_v);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s expected %h got %h", what, exp_v, act_v);
        endfunction

        // Compare one output transaction with the oldest owed rewrite.
        function void check_rewrite(t_rewrite got);
            t_rewrite want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with no packet outstanding, link %0d", got.link);
                return;
            end
            want = pending.pop_front();
            if (got.link !== want.link)
                flag("link_index", MAC_W'(want.link), MAC_W'(got.link));
            if (got.dst_mac !== want.dst_mac) flag("rewrite_dst_mac", want.dst_mac, got.dst_mac);
            if (got.src_mac !== want.src_mac) flag("rewrite_src_mac", want.src_mac, got.src_mac);
        endfunction
    endclass

    logic               i_clk;
    logic               rst_n      = 1'b0;
    logic               apb_sel    = 1'b0;
    logic               apb_enable = 1'b0;
    logic               apb_wr     = 1'b0;
    logic [PADDR_W-1:0] apb_addr   = '0;
    logic [PDATA_W-1:0] apb_wdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid   = 1'b0;
    logic               o_in_stall;
    logic [ADDR_W-1:0]  pkt_src    = '0;
    logic [ADDR_W-1:0]  pkt_dst    = '0;
    logic [LEN_W-1:0]   pkt_len    = '0;
    logic               o_out_valid;
    logic               out_stall  = 1'b0;
    logic [LINK_W-1:0]  o_link_index;
    logic [MAC_W-1:0]   o_rewrite_dst_mac;
    logic [MAC_W-1:0]   o_rewrite_src_mac;

    logic               quiet = 1'b0;
    int                 cycles = 0;
    rewrite_board #(FLOW_SLOTS) board;

    logic [ADDR_W-1:0]  pool_src [POOL_FLOWS];
    logic [ADDR_W-1:0]  pool_dst [POOL_FLOWS];

    flow_hash_wan_balancer_core #(
        .FLOW_ENTRIES(FLOW_SLOTS)
    ) u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (rst_n),
        .psel                 (apb_sel),
        .penable              (apb_enable),
        .pwrite               (apb_wr),
        .paddr                (apb_addr),
        .pwdata               (apb_wdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_source_address     (pkt_src),
        .i_destination_address(pkt_dst),
        .i_total_length       (pkt_len),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_link_index         (o_link_index),
        .o_rewrite_dst_mac    (o_rewrite_dst_mac),
        .o_rewrite_src_mac    (o_rewrite_src_mac)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Monitor: results are checked before the packet accepted at the same edge is noted.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_out_valid && !out_stall)
                board.check_rewrite('{o_link_index, o_rewrite_dst_mac, o_rewrite_src_mac});
            if (in_valid && !o_in_stall)
                board.note_packet(pkt_src, pkt_dst, pkt_len);
        end
    end

    // Result side: stall for a random number of cycles, then take one transaction.
    initial begin : result_side
        int hold;
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 11);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(rst_n && o_out_valid && !out_stall));
        end
    end

    // Setup then access, then an idle phase that keeps back-to-back writes apart.
    task automatic reg_write(input logic [REG_W-1:0] idx, input logic [PDATA_W-1:0] val);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_wr     <= 1'b1;
        apb_addr   <= PADDR_W'({idx, 3'b000});
        apb_wdata  <= val;
        @(posedge i_clk);
        apb_enable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, val);
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
        apb_wr     <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [MAC_W-1:0] pick_mac();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return MAC_W'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return LEN_W'($urandom_range(0, 1500));
            default: return LEN_W'($urandom());
        endcase
    endfunction

    // Writes every register: link count, window and fresh MAC pairs.
    task automatic configure(input int unsigned wans, input int unsigned win);
        reg_write(REG_NUM_WANS, PDATA_W'(wans));
        reg_write(REG_WINDOW_BYTES, PDATA_W'(win));
        reg_write(REG_WAN0_DST_MAC, PDATA_W'(pick_mac()));
        reg_write(REG_WAN1_DST_MAC, PDATA_W'(pick_mac()));
        reg_write(REG_WAN2_DST_MAC, PDATA_W'(pick_mac()));
        reg_write(REG_WAN0_SRC_MAC, PDATA_W'(pick_mac()));
        reg_write(REG_WAN1_SRC_MAC, PDATA_W'(pick_mac()));
        reg_write(REG_WAN2_SRC_MAC, PDATA_W'(pick_mac()));
    endtask

    // Drive one packet transaction and return at the edge that accepts it.
    task automatic send_packet(input logic [ADDR_W-1:0] s, input logic [ADDR_W-1:0] d,
                               input logic [LEN_W-1:0] l);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        pkt_src  <= s;
        pkt_dst  <= d;
        pkt_len  <= l;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Let every owed result come back, then idle the block for a drain period.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned phase_wans [8] = '{1, 3, 2, 0, 3, 1, 2, 3};
        int unsigned phase_win [8]  = '{65536, 1, 2097151, 0, 1048576, 5000, 300000, 70000};
        int          k;
        board = new();
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        // Registers are written while the table is still being cleared.
        configure(3, 1000);

        // Address and length extremes; both ends of the flow table.
        send_packet(32'h0000_0000, 32'h0000_0000, 16'h0000);
        send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_packet(32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
        send_packet(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        // One flow filling its window in steps, then a second flow that hashes
        // to the same slot and rotates on a sum exactly equal to the window.
        send_packet(32'h0A00_0001, 32'hC0A8_0001, 16'd400);
        send_packet(32'h0A00_0001, 32'hC0A8_0001, 16'd400);
        send_packet(32'h0A00_0001, 32'hC0A8_0001, 16'd400);
        send_packet(32'h0A00_2001, 32'hC0A8_0001, 16'd999);
        send_packet(32'h0A00_2001, 32'hC0A8_0001, 16'd1);
        send_packet(32'h0A00_0001, 32'hC0A8_0001, 16'd500);
        send_packet(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
        drain_results();

        // Largest window: counts build up without rotating.
        configure(3, 2097151);
        send_packet(32'h0A00_0001, 32'hC0A8_0001, 16'hFFFF);
        send_packet(32'h0A00_0001, 32'hC0A8_0001, 16'hFFFF);
        drain_results();

        // Window lowered under a stored count, and fewer links than a flow's stored link.
        configure(2, 100);
        send_packet(32'h0A00_0001, 32'hC0A8_0001, 16'd0);
        send_packet(32'hFFFF_FFFF, 32'h0000_0000, 16'd50);
        send_packet(32'hFFFF_FFFF, 32'h0000_0000, 16'd50);
        drain_results();

        // Zero link count and zero window: every packet rotates back to link 0.
        configure(0, 0);
        send_packet(32'h0000_0001, 32'h0000_0002, 16'd0);
        send_packet(32'h0000_0001, 32'h0000_0002, 16'd0);
        send_packet(32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        drain_results();

        // A small pool of flows, odd entries sharing the slot of the entry before them.
        for (int i = 0; i < POOL_FLOWS; i++) begin
            if (i % 2 == 1) begin
                pool_src[i] = pool_src[i-1] ^ ($urandom() << 13);
                pool_dst[i] = pool_dst[i-1];
            end else begin
                pool_src[i] = $urandom();
                pool_dst[i] = $urandom();
            end
        end

        // Random phases: mostly pooled flows so windows fill and links rotate.
        for (int p = 0; p < 8; p++) begin
            configure(phase_wans[p], phase_win[p]);
            quiet = (p % 3 == 2);
            for (int n = 0; n < 200; n++) begin
                k = $urandom_range(0, 15);
                if (k < POOL_FLOWS)
                    send_packet(pool_src[k], pool_dst[k], pick_len());
                else
                    send_packet($urandom(), $urandom(), pick_len());
            end
            drain_results();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
